// ===== rtl/core/one_dim_cellular_automaton_assert.svh =====
// Assertion macros for the one-dimensional cellular automaton.
// Used by the top level; no other dependencies.
`ifndef ONE_DIM_CELLULAR_AUTOMATON_ASSERT_SVH
`define ONE_DIM_CELLULAR_AUTOMATON_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cellular automaton check failed");

// Next-cycle implication, disabled during reset.
`define CA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cellular automaton check failed");

`endif

// ===== rtl/core/ca_pkg.sv =====
// Shared types and constants of the one-dimensional cellular automaton.
// No dependencies.
`timescale 1ns / 1ps

package ca_pkg;

    localparam int RULE_W  = 32;
    localparam int WIN_W   = 5;
    localparam int WORD_W  = 64;
    localparam int RAD_W   = 2;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_RULE_BITS = 2'd0;
    localparam logic [IDX_W-1:0] REG_RADIUS    = 2'd1;

    localparam logic [RAD_W-1:0] RADIUS_WIDE = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic ld;
        logic adv;
        logic wide;
    } ca_ctrl_t;

endpackage

// ===== rtl/core/ca_cell.sv =====
// One inner cell of the automaton row: holds one bit, looks up its next state.
// Depends on ca_pkg.
`timescale 1ns / 1ps

module ca_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ca_pkg::ca_ctrl_t           ctrl,
    input  logic [ca_pkg::RULE_W-1:0]  rule_bits,
    input  logic                       load_bit,
    input  logic [ca_pkg::WIN_W-1:0]   win,
    output logic                       state
);
    import ca_pkg::*;

    logic                 state_reg;
    logic                 state_next;
    logic [WIN_W-1:0]     k;

    // leftmost neighbor is the MSB of the window
    always_comb
    begin
        if (ctrl.wide)
        begin
            k = win;
        end
        else
        begin
            k = {2'b00, win[3:1]};
        end
        state_next = state_reg;
        if (ctrl.ld)
        begin
            state_next = load_bit;
        end
        else if (ctrl.adv)
        begin
            state_next = rule_bits[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ===== rtl/core/ca_row.sv =====
// Row of automaton cells; the two cells at each end stay dead.
// Depends on ca_pkg and ca_cell.
`timescale 1ns / 1ps

module ca_row #(
    parameter int FIELD_CELLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ca_pkg::ca_ctrl_t           ctrl,
    input  logic [ca_pkg::RULE_W-1:0]  rule_bits,
    input  logic [FIELD_CELLS-1:0]     load_word,
    output logic [FIELD_CELLS-1:0]     row
);
    import ca_pkg::*;

    assign row[1:0]                         = 2'b00;
    assign row[FIELD_CELLS-1:FIELD_CELLS-2] = 2'b00;

    for (genvar c = 2; c < FIELD_CELLS - 2; c++)
    begin : g_cell
        ca_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .rule_bits (rule_bits),
            .load_bit  (load_word[c]),
            .win       ({row[c-2], row[c-1], row[c], row[c+1], row[c+2]}),
            .state     (row[c])
        );
    end

endmodule

// ===== rtl/core/one_dim_cellular_automaton.sv =====
// Top level of the one-dimensional cellular automaton: handshakes and registers.
// Depends on ca_pkg, ca_row and one_dim_cellular_automaton_assert.svh.
//
// Usage:
//   Input stream s_axis: tuser[0] is the mode (0 load, 1 step), tdata the
//   field word (bit i is cell i). Output stream m_axis: tdata is the field
//   after the item, bits at and above FIELD_CELLS read zero.
//   Every accepted word gives exactly one output word, valid in the next
//   cycle. One word per cycle is taken while the receiver keeps
//   up, since every cell updates in parallel in the same clock.
//   When the receiver stalls, the result is held and s_axis_tready drops
//   until it is taken; the cell row itself is the output register.
//   Configuration: cfg_we with cfg_index 0 writes the rule word, 1 the
//   radius (2 selects five cells, anything else three). Write only while idle.
//   Reset: all cells dead, rule 30, radius 1, no pending output.
`timescale 1ns / 1ps
`include "one_dim_cellular_automaton_assert.svh"

module one_dim_cellular_automaton #(
    parameter int FIELD_CELLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ca_pkg::WORD_W-1:0]  s_axis_tdata,   // [63:0] field_word
    input  logic [0:0]                 s_axis_tuser,   // [0] mode
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ca_pkg::WORD_W-1:0]  m_axis_tdata,   // [63:0] field_out
    input  logic                       cfg_we,
    input  logic [ca_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ca_pkg::RULE_W-1:0]  cfg_data
);
    import ca_pkg::*;

    logic [RULE_W-1:0]       rule_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    accept;
    ca_ctrl_t                ctrl;
    logic [FIELD_CELLS-1:0]  row;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        ctrl.ld   = accept && (s_axis_tuser[0] == MODE_LOAD);
        ctrl.adv  = accept && (s_axis_tuser[0] == MODE_STEP);
        ctrl.wide = (radius_reg == RADIUS_WIDE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg   <= 32'd30;
            radius_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RULE_BITS: rule_reg   <= cfg_data;
                REG_RADIUS:    radius_reg <= cfg_data[RAD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    ca_row #(
        .FIELD_CELLS (FIELD_CELLS)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rule_bits (rule_reg),
        .load_word (s_axis_tdata[FIELD_CELLS-1:0]),
        .row       (row)
    );

    always_comb
    begin
        m_axis_tdata                = '0;
        m_axis_tdata[FIELD_CELLS-1:0] = row;
    end

    assign m_axis_tvalid = out_valid_reg;

    `CA_ASSERT_NOW(a_ends_dead, clk, rst_n, 1'b1, m_axis_tdata[1:0] == 2'b00 && m_axis_tdata[FIELD_CELLS-1:FIELD_CELLS-2] == 2'b00)
    `CA_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, accept, m_axis_tvalid)
    `CA_ASSERT_NEXT(a_taken_clears, clk, rst_n, m_axis_tvalid && m_axis_tready && !accept, !m_axis_tvalid)
    `CA_ASSERT_NEXT(a_load_inner, clk, rst_n, ctrl.ld, row[FIELD_CELLS-3:2] == $past(s_axis_tdata[FIELD_CELLS-3:2]))

endmodule
